[rtl/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg
// Types, constants and calendar lookup functions shared by the calendar date
// stepper controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_FWD  = 2'd1,
    MODE_BACK = 2'd2,
    MODE_NONE = 2'd3
  } cds_mode_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_YDIV,
    ST_SUM,
    ST_MOD,
    ST_DONE
  } cds_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic step;      // move the date by one day
    logic sat_set;   // step refused at a bound
    logic out_load;  // capture result into output register
  } cds_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cnt_zero;  // no days left to step
    logic at_bound;  // next step would cross the date range limit
  } cds_sts_t;

  // reset date
  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [13:0] RST_YEAR  = 14'd2000;

  // month codes used in the calendar logic
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_DEC = 4'd12;

  // floor(y/100) = (y * 5243) >> 19, exact for 14-bit y
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SHR = 19;

  // floor(j/7) = (j * 293) >> 11, exact for j below 600
  localparam logic [8:0]  MOD7_MUL = 9'd293;
  localparam int          MOD7_SHR = 11;

  // bias (multiple of 7) that keeps the weekday sum non-negative
  localparam logic [9:0]  WK_BIAS = 10'd350;

  // days in a month, february by leap flag
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month) inside
      MON_FEB:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // (13*m-1)/5 with m the march-based month number
  function automatic logic [4:0] zeller_month_term(input logic [3:0] month);
    logic [4:0] t;
    case (month)
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      4'd12:   t = 5'd25;
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      default: t = 5'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/cds_ctrl.sv]
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer for the date stepper: takes an input beat, walks the day steps,
// waits out the weekday pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_ctrl
  import cds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire cds_sts_t sts,
  output cds_cmd_t      cmd
);

  cds_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // output register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_STEP;
      ST_STEP: if (sts.cnt_zero || sts.at_bound) state_nxt = ST_YDIV;
      ST_YDIV: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MOD;
      ST_MOD:  state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: cmd.accept   = in_valid;
      ST_STEP: begin
        cmd.step    = !sts.cnt_zero && !sts.at_bound;
        cmd.sat_set = !sts.cnt_zero && sts.at_bound;
      end
      ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/cds_dpath.sv]
// ----------------------------------------------------------------------------
// cds_dpath
// Date registers with single-day step logic, leap-year tracking, a three
// stage weekday pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cds_dpath
  import cds_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cds_cmd_t    cmd,
  output cds_sts_t         sts,
  input  wire logic [1:0]  in_mode,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [13:0] in_load_year,
  input  wire logic [15:0] in_day_count,
  output logic [4:0]       out_cur_day,
  output logic [3:0]       out_cur_month,
  output logic [13:0]      out_cur_year,
  output logic [2:0]       out_weekday,
  output logic             out_saturated
);

  localparam logic [13:0] MaxYear = 14'(MAX_YEAR);

  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        dir_r, dir_nxt;
  logic        sat_r, sat_nxt;
  logic        leap_r, leap_nxt;
  logic [4:0]  dim_cur, dim_prev;
  logic [3:0]  month_prev;
  cds_mode_t   mode;

  logic [26:0] lp_prod;
  logic [7:0]  lp_cent;
  logic [6:0]  lp_rem;

  logic        wy_dec;
  logic [13:0] wy;
  logic [26:0] wy_prod;
  logic [7:0]  s_nxt, s_r;
  logic [6:0]  e_nxt, e_r;
  logic        neg_nxt, neg_r;
  logic [9:0]  s_term, s_twice;
  logic [9:0]  j_nxt, j_r;
  logic [18:0] q_prod;
  logic [6:0]  q7;
  logic [2:0]  wk_nxt, wk_r;

  assign mode = cds_mode_t'(in_mode);

  // status to the controller
  always_comb begin
    sts.cnt_zero = (cnt_r == 16'd0);
    if (dir_r) begin
      sts.at_bound = (year_r >= MaxYear) && (month_r == MON_DEC) && (day_r >= 5'd31);
    end else begin
      sts.at_bound = (year_r == 14'd0) && (month_r == MON_JAN) && (day_r == 5'd1);
    end
  end

  // month lengths for the current and previous month
  assign month_prev = (month_r == MON_JAN) ? MON_DEC : 4'(month_r - 4'd1);
  assign dim_cur    = month_days(month_r, leap_r);
  assign dim_prev   = month_days(month_prev, leap_r);

  // date next value: load or one day step
  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (cmd.accept && (mode == MODE_LOAD)) begin
      if ((in_load_month >= 4'd1) && (in_load_month <= MON_DEC)) month_nxt = in_load_month;
      if (in_load_year <= MaxYear) year_nxt = in_load_year;
      if (in_load_day != 5'd0) day_nxt = in_load_day;
    end else if (cmd.step) begin
      if (dir_r) begin
        if (day_r >= dim_cur) begin
          day_nxt = 5'd1;
          if (month_r == MON_DEC) begin
            month_nxt = MON_JAN;
            year_nxt  = 14'(year_r + 14'd1);
          end else begin
            month_nxt = 4'(month_r + 4'd1);
          end
        end else begin
          day_nxt = 5'(day_r + 5'd1);
        end
      end else begin
        if (day_r == 5'd1) begin
          month_nxt = month_prev;
          day_nxt   = dim_prev;
          if (month_r == MON_JAN) year_nxt = 14'(year_r - 14'd1);
        end else begin
          day_nxt = 5'(day_r - 5'd1);
        end
      end
    end
  end

  // step count, direction and saturation flag
  always_comb begin
    cnt_nxt = cnt_r;
    dir_nxt = dir_r;
    sat_nxt = sat_r;
    if (cmd.accept) begin
      cnt_nxt = ((mode == MODE_FWD) || (mode == MODE_BACK)) ? in_day_count : 16'd0;
      dir_nxt = (mode == MODE_FWD);
      sat_nxt = 1'b0;
    end else if (cmd.step) begin
      cnt_nxt = 16'(cnt_r - 16'd1);
    end else if (cmd.sat_set) begin
      sat_nxt = 1'b1;
    end
  end

  // leap flag of the held year, registered so it follows the year in the next cycle
  always_comb begin
    lp_prod  = 27'(year_r) * 27'(DIV100_MUL);
    lp_cent  = 8'(lp_prod >> DIV100_SHR);
    lp_rem   = 7'(year_r - 14'(lp_cent) * 14'd100);
    leap_nxt = (year_r[1:0] == 2'b00) && ((lp_rem != 7'd0) || (lp_cent[1:0] == 2'b00));
  end

  // weekday stage 1: century and year of century of the march-based year
  always_comb begin
    wy_dec  = (month_r <= MON_FEB);
    neg_nxt = wy_dec && (year_r == 14'd0);
    wy      = 14'(year_r - {13'd0, wy_dec});
    wy_prod = 27'(wy) * 27'(DIV100_MUL);
    s_nxt   = neg_nxt ? 8'd0 : 8'(wy_prod >> DIV100_SHR);
    e_nxt   = neg_nxt ? 7'd99 : 7'(wy - 14'(s_nxt) * 14'd100);
  end

  // weekday stage 2: biased zeller sum
  always_comb begin
    s_term  = neg_r ? 10'd1 : 10'(s_r >> 2);
    s_twice = neg_r ? 10'd0 : {1'b0, s_r, 1'b0};
    j_nxt   = 10'(10'(day_r) + 10'(zeller_month_term(month_r)) + 10'(e_r)
                + 10'(e_r >> 2) + WK_BIAS + s_term - s_twice);
  end

  // weekday stage 3: sum modulo seven
  always_comb begin
    q_prod = 19'(j_r) * 19'(MOD7_MUL);
    q7     = 7'(q_prod >> MOD7_SHR);
    wk_nxt = 3'(j_r - 10'(q7) * 10'd7);
  end

  // date and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= RST_DAY;
      month_r <= RST_MONTH;
      year_r  <= RST_YEAR;
      sat_r   <= 1'b0;
      leap_r  <= 1'b1;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
      sat_r   <= sat_nxt;
      leap_r  <= leap_nxt;
    end
  end

  // step counter and weekday pipeline
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dir_r <= dir_nxt;
    s_r   <= s_nxt;
    e_r   <= e_nxt;
    neg_r <= neg_nxt;
    j_r   <= j_nxt;
    wk_r  <= wk_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cur_day   <= day_r;
      out_cur_month <= month_r;
      out_cur_year  <= year_r;
      out_weekday   <= wk_r;
      out_saturated <= sat_r;
    end
  end

endmodule

`default_nettype wire

[rtl/calendar_date_stepper.sv]
// ----------------------------------------------------------------------------
// calendar_date_stepper
// Holds a gregorian date; each input beat loads it, steps it forward or back
// by a day count or leaves it, and each beat yields the date and its weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): in_mode selects load (0), step
//   forward (1), step back (2) or no change (3). A load takes each of
//   in_load_day / in_load_month / in_load_year only if it is in range.
//   Result channel (out_valid / out_stall): one beat per input beat with the
//   date, weekday (0 = sunday) and a flag set when a step ran into 1 jan 0
//   or 31 dec MAX_YEAR with days left, which are dropped.
//   Timing: one item at a time; the date moves one day per clock, so an item
//   takes longer from acceptance to out_valid the more days it actually steps
//   (none for loads); the day stepping loop is followed by the weekday
//   pipeline.
//   in_stall is high while an item is in work. A finished result sits in the
//   output register; the next item may be accepted while it waits, and that
//   item's own result waits until the receiver lowers out_stall.
//   Reset (rst_n low, synchronous) sets the date to 1 jan 2000 and empties
//   the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_stepper
  import cds_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [4:0]  in_load_day,
  input  wire logic [3:0]  in_load_month,
  input  wire logic [13:0] in_load_year,
  input  wire logic [15:0] in_day_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_cur_day,
  output logic [3:0]       out_cur_month,
  output logic [13:0]      out_cur_year,
  output logic [2:0]       out_weekday,
  output logic             out_saturated
);

  cds_cmd_t cmd;
  cds_sts_t sts;

  // sequencer
  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // date datapath
  cds_dpath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_mode),
    .in_load_day   (in_load_day),
    .in_load_month (in_load_month),
    .in_load_year  (in_load_year),
    .in_day_count  (in_day_count),
    .out_cur_day   (out_cur_day),
    .out_cur_month (out_cur_month),
    .out_cur_year  (out_cur_year),
    .out_weekday   (out_weekday),
    .out_saturated (out_saturated)
  );

  // a step is only issued with days left and never together with saturation
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!sts.cnt_zero && !cmd.sat_set))
    else $error("step issued with no count left or at a bound");

  // reported month stays in range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_cur_month >= 4'd1) && (out_cur_month <= MON_DEC)))
    else $error("result month out of range");

  // reported day is never zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cur_day != 5'd0))
    else $error("result day is zero");

  // a saturated result sits on one of the two bound dates
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      ((out_cur_year == 14'd0 && out_cur_month == MON_JAN && out_cur_day == 5'd1) ||
       (out_cur_month == MON_DEC && out_cur_day == 5'd31)))
    else $error("saturated result not at a bound date");

  // result beat is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[tb/calendar_date_stepper_tb.sv]
// ----------------------------------------------------------------------------
// calendar_date_stepper_tb
// Self-checking bench for the calendar date stepper. A short directed table
// covers the range ends, bad load fields, dates past the end of their month
// and saturation at both ends of the calendar. A long random run follows:
// loads, many near leap and century years and the calendar bounds, mixed with
// forward and back steps and no-change beats. Every result beat is checked
// against its typed expectation or an in-bench calendar model. Both sides
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module calendar_date_stepper_tb;
  import cds_pkg::*;

  localparam int MAX_YEAR        = 9999;
  localparam int RANDOM_ITEMS    = 880;
  localparam int IDLE_MAX        = 13;
  localparam int HOLD_OFF_BEAT   = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 5_000_000;
  localparam int BIG_STEP_SLOT   = 37;

  // one result beat: date, weekday and saturation flag
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  wday;
    logic        sat;
  } date_beat_t;

  // one row of the directed table
  typedef struct packed {
    cds_mode_t   mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] count;
    logic        typed;
    date_beat_t  golden;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_NONE;
  logic [4:0]  in_load_day = '0;
  logic [3:0]  in_load_month = '0;
  logic [13:0] in_load_year = '0;
  logic [15:0] in_day_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_cur_day;
  logic [3:0]  out_cur_month;
  logic [13:0] out_cur_year;
  logic [2:0]  out_weekday;
  logic        out_saturated;

  // typed expectation travels with the input beat
  logic        golden_typed = 1'b0;
  date_beat_t  golden_beat = '0;

  // calendar model state
  int cal_day   = RST_DAY;
  int cal_month = RST_MONTH;
  int cal_year  = RST_YEAR;

  date_beat_t  pending_dates[$];
  stim_row_t   directed_rows[$];
  int          fail_count = 0;
  int          beats_sent = 0;

  calendar_date_stepper #(
    .MAX_YEAR(MAX_YEAR)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_load_day  (in_load_day),
    .in_load_month(in_load_month),
    .in_load_year (in_load_year),
    .in_day_count (in_day_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_cur_day  (out_cur_day),
    .out_cur_month(out_cur_month),
    .out_cur_year (out_cur_year),
    .out_weekday  (out_weekday),
    .out_saturated(out_saturated)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gregorian leap rule, year 0 included
  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_length(input int m, input int y);
    int n;
    case (m)
      2:           n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // zeller congruence, 0 = sunday; jan and feb of year 0 fall in year -1
  function automatic logic [2:0] zeller_weekday(input int d, input int mon, input int yr);
    int m, y, s, e, j;
    m = mon - 2;
    y = yr;
    if (m <= 0) begin
      m += 12;
      y -= 1;
    end
    if (y < 0) begin
      s = -1;
      e = 99;
    end else begin
      s = y / 100;
      e = y % 100;
    end
    j = d + (13 * m - 1) / 5 + e + e / 4 + ((s < 0) ? -1 : s / 4) - 2 * s;
    j = j % 7;
    if (j < 0) j += 7;
    return j[2:0];
  endfunction

  // apply one input beat to the calendar model and give the result beat
  function automatic date_beat_t step_calendar(input cds_mode_t mode, input int ld,
                                               input int lm, input int ly, input int cnt);
    date_beat_t r;
    int left;
    bit sat;
    sat = 1'b0;
    left = cnt;
    case (mode)
      MODE_LOAD: begin
        if (lm >= 1 && lm <= 12) cal_month = lm;
        if (ly <= MAX_YEAR) cal_year = ly;
        if (ld >= 1 && ld <= 31) cal_day = ld;
      end
      MODE_FWD: begin
        while (left > 0 && !sat) begin
          if (cal_year >= MAX_YEAR && cal_month == 12 && cal_day >= 31) begin
            sat = 1'b1;
          end else begin
            cal_day++;
            if (cal_day > month_length(cal_month, cal_year)) begin
              cal_day = 1;
              cal_month++;
              if (cal_month > 12) begin
                cal_month = 1;
                cal_year++;
              end
            end
            left--;
          end
        end
      end
      MODE_BACK: begin
        while (left > 0 && !sat) begin
          if (cal_year == 0 && cal_month == 1 && cal_day == 1) begin
            sat = 1'b1;
          end else begin
            cal_day--;
            if (cal_day == 0) begin
              cal_month--;
              if (cal_month == 0) begin
                cal_month = 12;
                cal_year--;
              end
              cal_day = month_length(cal_month, cal_year);
            end
            left--;
          end
        end
      end
      default: ;
    endcase
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    r.wday  = zeller_weekday(cal_day, cal_month, cal_year);
    r.sat   = sat;
    return r;
  endfunction

  task automatic add_row(input cds_mode_t mode, input int d, input int m, input int y,
                         input int cnt, input bit typed, input int gd, input int gm,
                         input int gy, input int gw, input int gs);
    stim_row_t row;
    row.mode         = mode;
    row.day          = d;
    row.month        = m;
    row.year         = y;
    row.count        = cnt;
    row.typed        = typed;
    row.golden.day   = gd;
    row.golden.month = gm;
    row.golden.year  = gy;
    row.golden.wday  = gw;
    row.golden.sat   = gs;
    directed_rows.push_back(row);
  endtask

  // offer one input beat after a random gap and wait until it is taken
  task automatic send_beat(input cds_mode_t mode, input logic [4:0] d, input logic [3:0] m,
                           input logic [13:0] y, input logic [15:0] cnt, input logic typed,
                           input date_beat_t golden);
    int gap;
    gap = ((beats_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, IDLE_MAX);
    beats_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_load_day   <= d;
    in_load_month <= m;
    in_load_year  <= y;
    in_day_count  <= cnt;
    golden_typed  <= typed;
    golden_beat   <= golden;
    do @(posedge clk); while (in_stall);
  endtask

  // predict on every accepted input beat, check every accepted result beat
  always @(posedge clk) begin : beat_monitor
    date_beat_t predicted;
    date_beat_t want;
    if (rst_n && in_valid && !in_stall) begin
      predicted = step_calendar(cds_mode_t'(in_mode), in_load_day, in_load_month,
                                in_load_year, in_day_count);
      pending_dates.push_back(golden_typed ? golden_beat : predicted);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        if (fail_count < 10)
          $display("unexpected result beat: %0d/%0d/%0d wd %0d sat %0d",
                   out_cur_day, out_cur_month, out_cur_year, out_weekday, out_saturated);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_cur_day !== want.day || out_cur_month !== want.month ||
            out_cur_year !== want.year || out_weekday !== want.wday ||
            out_saturated !== want.sat) begin
          if (fail_count < 10)
            $display("mismatch: expected %0d/%0d/%0d wd %0d sat %0d, got %0d/%0d/%0d wd %0d sat %0d",
                     want.day, want.month, want.year, want.wday, want.sat,
                     out_cur_day, out_cur_month, out_cur_year, out_weekday, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // result side: random stall per beat, quiet stretches, one long hold-off
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_OFF_BEAT) hold = HOLD_OFF_CYCLES;
      else if ((taken / 40) % 4 == 1) hold = 0;
      else hold = $urandom_range(0, IDLE_MAX);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    cds_mode_t  mode;
    int         pick, d, m, y, cnt;
    date_beat_t no_golden;
    no_golden = '0;

    // directed table: mode, load fields, count, typed flag, expected beat
    add_row(MODE_NONE,  0,  0,     0,     0, 1,  1,  1, 2000, 6, 0);
    add_row(MODE_LOAD, 31, 12,  9999,     0, 1, 31, 12, 9999, 5, 0);
    add_row(MODE_FWD,   0,  0,     0,     1, 1, 31, 12, 9999, 5, 1);
    add_row(MODE_FWD,   0,  0,     0, 65535, 1, 31, 12, 9999, 5, 1);
    add_row(MODE_LOAD,  1,  1,     0, 65535, 1,  1,  1,    0, 6, 0);
    add_row(MODE_BACK,  0,  0,     0,     1, 1,  1,  1,    0, 6, 1);
    add_row(MODE_FWD,   0,  0,     0,     0, 1,  1,  1,    0, 6, 0);
    add_row(MODE_FWD,  31, 15, 16383, 65535, 0,  0,  0,    0, 0, 0);
    add_row(MODE_LOAD,  0,  0, 16383,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_LOAD, 31, 15, 10000,     0, 0,  0,  0,    0, 0, 0);
    // leap day in a year divisible by 400
    add_row(MODE_LOAD, 29,  2,  2000,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_FWD,   0,  0,     0,     1, 0,  0,  0,    0, 0, 0);
    // day past the end of february, back then forward
    add_row(MODE_LOAD, 31,  2,  2001,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_BACK,  0,  0,     0,     1, 0,  0,  0,    0, 0, 0);
    add_row(MODE_FWD,   0,  0,     0,     1, 0,  0,  0,    0, 0, 0);
    add_row(MODE_LOAD,  1,  3,  2000,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_BACK,  0,  0,     0,     1, 0,  0,  0,    0, 0, 0);
    // reach a bound with the count just used up
    add_row(MODE_LOAD, 30, 12,  9999,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_FWD,   0,  0,     0,     1, 1, 31, 12, 9999, 5, 0);
    add_row(MODE_LOAD,  1,  1,     1,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_BACK,  0,  0,     0,   366, 1,  1,  1,    0, 6, 0);
    // run into a bound with days left over
    add_row(MODE_LOAD,  1,  1,     2,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_BACK,  0,  0,     0,   800, 1,  1,  1,    0, 6, 1);
    add_row(MODE_LOAD, 31, 12,  9997,     0, 0,  0,  0,    0, 0, 0);
    add_row(MODE_FWD,   0,  0,     0,  1000, 1, 31, 12, 9999, 5, 1);

    // reset
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].mode, directed_rows[i].day, directed_rows[i].month,
                directed_rows[i].year, directed_rows[i].count, directed_rows[i].typed,
                directed_rows[i].golden);

    // random part: loads of interesting dates followed by steps, some noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      d    = $urandom_range(0, 31);
      m    = $urandom_range(0, 15);
      y    = $urandom_range(0, 16383);
      cnt  = $urandom_range(0, 65535);
      if (k % 100 == BIG_STEP_SLOT) mode = ($urandom_range(0, 1) != 0) ? MODE_FWD : MODE_BACK;
      else if (pick < 25) mode = MODE_LOAD;
      else if (pick < 57) mode = MODE_FWD;
      else if (pick < 90) mode = MODE_BACK;
      else mode = MODE_NONE;

      if (mode == MODE_LOAD) begin
        case ($urandom_range(0, 7))
          0:       d = 0;
          1, 2:    d = $urandom_range(28, 31);
          default: d = $urandom_range(1, 31);
        endcase
        if ($urandom_range(0, 9) != 0) m = $urandom_range(1, 12);
        case ($urandom_range(0, 9))
          0:       y = $urandom_range(0, 3);
          1, 2:    y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
          3, 4:    y = 100 * $urandom_range(15, 25) + $urandom_range(0, 2) - 1;
          5:       y = $urandom_range(MAX_YEAR + 1, 16383);
          default: y = $urandom_range(0, MAX_YEAR);
        endcase
      end else if (mode != MODE_NONE && k % 100 != BIG_STEP_SLOT) begin
        // short steps keep the run fast
        cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 31);
      end
      send_beat(mode, d, m, y, cnt, 1'b0, no_golden);
    end
    in_valid <= 1'b0;

    // drain
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
